>>> design/rgbv_pkg.sv
// Package for the RGB color class vote: class codes, register map and threshold set.
`default_nettype none
package rgbv_pkg;

  localparam int CLS_W = 3;
  localparam int LVL_W = 8;
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = 3;

  localparam logic [CLS_W-1:0] CLS_NONE   = 3'd0;
  localparam logic [CLS_W-1:0] CLS_WHITE  = 3'd1;
  localparam logic [CLS_W-1:0] CLS_YELLOW = 3'd2;
  localparam logic [CLS_W-1:0] CLS_RED    = 3'd3;
  localparam logic [CLS_W-1:0] CLS_GREEN  = 3'd4;
  localparam logic [CLS_W-1:0] CLS_BLUE   = 3'd5;
  localparam logic [CLS_W-1:0] CLS_BLACK  = 3'd6;

  localparam logic [REG_IDX_W-1:0] REG_WHITE_MIN         = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_YELLOW_RG_MIN     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_YELLOW_BLUE_MAX   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RED_MIN           = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RED_MARGIN        = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GREEN_BLUE_MIN    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GREEN_BLUE_MARGIN = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_BLACK_MAX         = 3'd7;

  typedef logic [LVL_W-1:0] level_t;
  typedef logic [CLS_W-1:0] class_t;

  typedef struct packed {
    level_t white_min;
    level_t yellow_rg_min;
    level_t yellow_blue_max;
    level_t red_min;
    level_t red_margin;
    level_t green_blue_min;
    level_t green_blue_margin;
    level_t black_max;
  } thresh_t;

  function automatic level_t reg_reset_val(input logic [REG_IDX_W-1:0] idx);
    level_t v;
    case (idx)
      REG_WHITE_MIN:         v = 8'd130;
      REG_YELLOW_RG_MIN:     v = 8'd120;
      REG_YELLOW_BLUE_MAX:   v = 8'd100;
      REG_RED_MIN:           v = 8'd80;
      REG_RED_MARGIN:        v = 8'd30;
      REG_GREEN_BLUE_MIN:    v = 8'd65;
      REG_GREEN_BLUE_MARGIN: v = 8'd20;
      REG_BLACK_MAX:         v = 8'd60;
      default:               v = 8'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> design/rgbv_if.sv
// Valid/ready channel interfaces for the reading input and the class result.
`default_nettype none
interface rgbv_in_if;
  logic                  valid;
  logic                  ready;
  rgbv_pkg::level_t      red_level;
  rgbv_pkg::level_t      green_level;
  rgbv_pkg::level_t      blue_level;
  logic                  reading_valid;
  rgbv_pkg::class_t      target_class;

  modport source (output valid, red_level, green_level, blue_level, reading_valid,
                  target_class, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, reading_valid,
                  target_class, output ready);
endinterface

interface rgbv_out_if;
  logic                  valid;
  logic                  ready;
  rgbv_pkg::class_t      color_class;
  logic                  confirmed;

  modport source (output valid, color_class, confirmed, input ready);
  modport sink   (input valid, color_class, confirmed, output ready);
endinterface
`default_nettype wire

>>> design/rgbv_classify.sv
// Ordered threshold classifier for one RGB reading.
`default_nettype none
module rgbv_classify (
  input  wire rgbv_pkg::level_t  red_level,
  input  wire rgbv_pkg::level_t  green_level,
  input  wire rgbv_pkg::level_t  blue_level,
  input  wire logic              reading_valid,
  input  wire rgbv_pkg::thresh_t thr,
  output rgbv_pkg::class_t       color_class
);

  logic [rgbv_pkg::LVL_W:0] r9, g9, b9;
  logic [rgbv_pkg::LVL_W:0] g_rm, b_rm, r_gm, g_gm, b_gm;
  logic is_white, is_yellow, is_red, is_green, is_blue, is_black;

  assign r9 = {1'b0, red_level};
  assign g9 = {1'b0, green_level};
  assign b9 = {1'b0, blue_level};

  // margins added at 9 bits so nothing wraps
  assign g_rm = g9 + {1'b0, thr.red_margin};
  assign b_rm = b9 + {1'b0, thr.red_margin};
  assign r_gm = r9 + {1'b0, thr.green_blue_margin};
  assign g_gm = g9 + {1'b0, thr.green_blue_margin};
  assign b_gm = b9 + {1'b0, thr.green_blue_margin};

  assign is_white  = (red_level > thr.white_min) && (green_level > thr.white_min) &&
                     (blue_level > thr.white_min);
  assign is_yellow = (red_level > thr.yellow_rg_min) && (green_level > thr.yellow_rg_min) &&
                     (blue_level < thr.yellow_blue_max);
  assign is_red    = (red_level > thr.red_min) && (r9 > g_rm) && (r9 > b_rm);
  assign is_green  = (green_level > thr.green_blue_min) && (g9 > r_gm) && (g9 > b_gm);
  assign is_blue   = (blue_level > thr.green_blue_min) && (b9 > r_gm) && (b9 > g_gm);
  assign is_black  = (red_level < thr.black_max) && (green_level < thr.black_max) &&
                     (blue_level < thr.black_max);

  always_comb begin
    if (!reading_valid)  color_class = rgbv_pkg::CLS_NONE;
    else if (is_white)   color_class = rgbv_pkg::CLS_WHITE;
    else if (is_yellow)  color_class = rgbv_pkg::CLS_YELLOW;
    else if (is_red)     color_class = rgbv_pkg::CLS_RED;
    else if (is_green)   color_class = rgbv_pkg::CLS_GREEN;
    else if (is_blue)    color_class = rgbv_pkg::CLS_BLUE;
    else if (is_black)   color_class = rgbv_pkg::CLS_BLACK;
    else                 color_class = rgbv_pkg::CLS_NONE;
  end

endmodule
`default_nettype wire

>>> design/rgbv_cell.sv
// One history cell: holds a past class, passes it down the chain and flags a target hit.
`default_nettype none
module rgbv_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             shift_en,
  input  wire rgbv_pkg::class_t cls_in,
  input  wire rgbv_pkg::class_t target,
  output rgbv_pkg::class_t      cls_out,
  output logic                  hit
);

  rgbv_pkg::class_t cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r <= rgbv_pkg::CLS_NONE;
    end else if (shift_en) begin
      cls_r <= cls_in;
    end
  end

  assign cls_out = cls_r;
  // compare the value this cell takes on the shift
  assign hit = (cls_in == target);

endmodule
`default_nettype wire

>>> design/rgb_color_class_vote.sv
// Top level: classifier, chain of history cells, vote count and output register.
// Classify, cell compares and vote count share the accept cycle; the result is registered
// and offered the cycle after; one beat per cycle unless the output stalls.
// in.ready stays high while the output register is empty or being taken.
// Reset (synchronous, rst_n low): history cells clear to none, thresholds take their
// defaults, output register empties.
`default_nettype none
module rgb_color_class_vote #(
  parameter int HISTORY_DEPTH = 5
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  rgbv_in_if.sink                                  in,
  rgbv_out_if.source                               out,
  input  wire logic                                cfg_we,
  input  wire logic [rgbv_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire rgbv_pkg::level_t                    cfg_data
);

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int VOTE_MIN = HISTORY_DEPTH - 1;

  rgbv_pkg::level_t  cfg_r [rgbv_pkg::NUM_REGS];
  rgbv_pkg::thresh_t thr;
  rgbv_pkg::class_t  cls;
  rgbv_pkg::class_t  chain [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hits;
  logic [CNT_W-1:0]  hit_cnt;
  logic              accept;
  logic              out_valid_r, out_valid_nxt;
  rgbv_pkg::class_t  out_class_r;
  logic              out_conf_r;
  logic              confirmed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rgbv_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= rgbv_pkg::reg_reset_val(rgbv_pkg::REG_IDX_W'(i));
      end
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  assign thr.white_min         = cfg_r[rgbv_pkg::REG_WHITE_MIN];
  assign thr.yellow_rg_min     = cfg_r[rgbv_pkg::REG_YELLOW_RG_MIN];
  assign thr.yellow_blue_max   = cfg_r[rgbv_pkg::REG_YELLOW_BLUE_MAX];
  assign thr.red_min           = cfg_r[rgbv_pkg::REG_RED_MIN];
  assign thr.red_margin        = cfg_r[rgbv_pkg::REG_RED_MARGIN];
  assign thr.green_blue_min    = cfg_r[rgbv_pkg::REG_GREEN_BLUE_MIN];
  assign thr.green_blue_margin = cfg_r[rgbv_pkg::REG_GREEN_BLUE_MARGIN];
  assign thr.black_max         = cfg_r[rgbv_pkg::REG_BLACK_MAX];

  assign in.ready = !out_valid_r || out.ready;
  assign accept   = in.valid && in.ready;

  rgbv_classify u_classify (
    .red_level     (in.red_level),
    .green_level   (in.green_level),
    .blue_level    (in.blue_level),
    .reading_valid (in.reading_valid),
    .thr           (thr),
    .color_class   (cls)
  );

  // new class enters cell 0; the oldest falls off the far end
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    rgbv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .cls_in   ((i == 0) ? cls : chain[(i == 0) ? 0 : i - 1]),
      .target   (in.target_class),
      .cls_out  (chain[i]),
      .hit      (hits[i])
    );
  end

  assign hit_cnt       = CNT_W'($countones(hits));
  assign confirmed_nxt = (hit_cnt >= CNT_W'(VOTE_MIN));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept)         out_valid_nxt = 1'b1;
    else if (out.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_class_r <= cls;
      out_conf_r  <= confirmed_nxt;
    end
  end

  assign out.valid       = out_valid_r;
  assign out.color_class = out_class_r;
  assign out.confirmed   = out_conf_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out.valid)
    else $error("accepted beat did not produce a result beat");

  a_invalid_none: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in.reading_valid |=> out.color_class == rgbv_pkg::CLS_NONE)
    else $error("invalid reading not classed as none");

  a_head_cell: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> chain[0] == out.color_class)
    else $error("head cell does not hold the latest class");

  a_target_seven: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in.target_class == 3'd7 |=> !out.confirmed)
    else $error("unused target code confirmed");

endmodule
`default_nettype wire

>>> test/tb.sv
// Testbench for rgb_color_class_vote: random traffic on both channels, vote predictor.
module tb;

  localparam int DEPTH = 5;
  localparam int RUN_READINGS = 200;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    rgbv_pkg::level_t red;
    rgbv_pkg::level_t green;
    rgbv_pkg::level_t blue;
    logic             vld;
    rgbv_pkg::class_t target;
  } reading_t;

  typedef struct packed {
    rgbv_pkg::class_t cls;
    logic             confirmed;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  always #1 clk = ~clk;

  rgbv_in_if  in_ch ();
  rgbv_out_if out_ch ();
  logic                           cfg_we;
  logic [rgbv_pkg::REG_IDX_W-1:0] cfg_index;
  rgbv_pkg::level_t               cfg_data;

  rgb_color_class_vote #(.HISTORY_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in        (in_ch),
    .out       (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rgbv_pkg::thresh_t thr;
  rgbv_pkg::class_t  class_log [DEPTH];
  int       log_slot;
  reading_t pending_readings [$];
  verdict_t awaited_verdicts [$];
  int       mismatches;
  int       cycles;
  bit       in_beat_taken;
  bit       out_beat_taken;
  int       send_hold;
  int       recv_hold;
  bit       send_burst;
  bit       recv_burst;

  function automatic rgbv_pkg::class_t classify_reading(reading_t rd, rgbv_pkg::thresh_t t);
    logic [8:0] r, g, b;
    r = {1'b0, rd.red};
    g = {1'b0, rd.green};
    b = {1'b0, rd.blue};
    if (!rd.vld)
      return rgbv_pkg::CLS_NONE;
    if (r > t.white_min && g > t.white_min && b > t.white_min)
      return rgbv_pkg::CLS_WHITE;
    if (r > t.yellow_rg_min && g > t.yellow_rg_min && b < t.yellow_blue_max)
      return rgbv_pkg::CLS_YELLOW;
    if (r > t.red_min && r > g + t.red_margin && r > b + t.red_margin)
      return rgbv_pkg::CLS_RED;
    if (g > t.green_blue_min && g > r + t.green_blue_margin && g > b + t.green_blue_margin)
      return rgbv_pkg::CLS_GREEN;
    if (b > t.green_blue_min && b > r + t.green_blue_margin && b > g + t.green_blue_margin)
      return rgbv_pkg::CLS_BLUE;
    if (r < t.black_max && g < t.black_max && b < t.black_max)
      return rgbv_pkg::CLS_BLACK;
    return rgbv_pkg::CLS_NONE;
  endfunction

  function automatic rgbv_pkg::level_t near_level(rgbv_pkg::level_t v);
    int x;
    x = int'(v) + int'($urandom_range(0, 4)) - 2;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return rgbv_pkg::level_t'(x);
  endfunction

  function automatic reading_t random_reading(rgbv_pkg::thresh_t t);
    reading_t         rd;
    rgbv_pkg::level_t pick [8];
    rd = '0;
    rd.vld = ($urandom_range(0, 7) != 0);
    rd.target = rgbv_pkg::class_t'($urandom_range(0, 7));
    case ($urandom_range(0, 4))
      0: begin
        rd.red = rgbv_pkg::level_t'($urandom);
        rd.green = rgbv_pkg::level_t'($urandom);
        rd.blue = rgbv_pkg::level_t'($urandom);
      end
      1: begin
        // one channel is drawn from a higher range than the other two
        rd.red = rgbv_pkg::level_t'($urandom_range(0, 90));
        rd.green = rgbv_pkg::level_t'($urandom_range(0, 90));
        rd.blue = rgbv_pkg::level_t'($urandom_range(0, 90));
        case ($urandom_range(0, 2))
          0: rd.red = rgbv_pkg::level_t'($urandom_range(60, 255));
          1: rd.green = rgbv_pkg::level_t'($urandom_range(60, 255));
          default: rd.blue = rgbv_pkg::level_t'($urandom_range(60, 255));
        endcase
      end
      2: begin
        rd.red = rgbv_pkg::level_t'($urandom_range(100, 255));
        rd.green = rgbv_pkg::level_t'($urandom_range(100, 255));
        rd.blue = rgbv_pkg::level_t'($urandom_range(0, 255));
      end
      3: begin
        rd.red = rgbv_pkg::level_t'($urandom_range(0, 70));
        rd.green = rgbv_pkg::level_t'($urandom_range(0, 70));
        rd.blue = rgbv_pkg::level_t'($urandom_range(0, 70));
      end
      default: begin
        // sit on the edge of some threshold
        pick = '{t.white_min, t.yellow_rg_min, t.yellow_blue_max, t.red_min,
                 t.red_margin, t.green_blue_min, t.green_blue_margin, t.black_max};
        rd.red = near_level(pick[$urandom_range(0, 7)]);
        rd.green = near_level(pick[$urandom_range(0, 7)]);
        rd.blue = near_level(pick[$urandom_range(0, 7)]);
      end
    endcase
    return rd;
  endfunction

  function automatic void add_reading(int r, int g, int b, bit v, rgbv_pkg::class_t tgt);
    reading_t rd;
    rd.red = rgbv_pkg::level_t'(r);
    rd.green = rgbv_pkg::level_t'(g);
    rd.blue = rgbv_pkg::level_t'(b);
    rd.vld = v;
    rd.target = tgt;
    pending_readings.push_back(rd);
  endfunction

  // Mostly runs of one reading with a fixed target, so the vote can reach four of five.
  function automatic void queue_runs(int count);
    reading_t         base, rd;
    rgbv_pkg::class_t tgt;
    int               len, n;
    n = 0;
    while (n < count) begin
      base = random_reading(thr);
      if ($urandom_range(0, 6) == 0) begin
        pending_readings.push_back(base);
        n++;
      end else begin
        tgt = ($urandom_range(0, 9) < 7) ? classify_reading(base, thr)
                                         : rgbv_pkg::class_t'($urandom_range(0, 7));
        len = $urandom_range(3, 8);
        for (int i = 0; i < len; i++) begin
          rd = ($urandom_range(0, 4) == 0) ? random_reading(thr) : base;
          rd.target = tgt;
          pending_readings.push_back(rd);
        end
        n += len;
      end
    end
  endfunction

  task automatic drain();
    while (pending_readings.size() != 0 || in_ch.valid || awaited_verdicts.size() != 0)
      @(negedge clk);
  endtask

  // Call at a falling edge with both channels quiet.
  task automatic load_thresholds(rgbv_pkg::thresh_t t);
    rgbv_pkg::level_t vals [8];
    vals = '{t.white_min, t.yellow_rg_min, t.yellow_blue_max, t.red_min,
             t.red_margin, t.green_blue_min, t.green_blue_margin, t.black_max};
    for (int i = 0; i < rgbv_pkg::NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= rgbv_pkg::REG_IDX_W'(i);
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    thr = t;
    @(posedge clk);
  endtask

  // Sender: hold a beat until taken, then idle for its drawn gap.
  always @(negedge clk) begin
    reading_t rd;
    if (rst_n && (!in_ch.valid || in_beat_taken)) begin
      if (send_hold > 0) begin
        in_ch.valid <= 1'b0;
        send_hold--;
      end else if (pending_readings.size() != 0) begin
        rd = pending_readings.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.red_level <= rd.red;
        in_ch.green_level <= rd.green;
        in_ch.blue_level <= rd.blue;
        in_ch.reading_valid <= rd.vld;
        in_ch.target_class <= rd.target;
        send_hold = send_burst ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 59) == 0) send_burst = !send_burst;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall for a drawn number of cycles after each result beat.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_beat_taken) begin
        recv_hold = recv_burst ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 59) == 0) recv_burst = !recv_burst;
      end
      if (recv_hold > 0) begin
        out_ch.ready <= 1'b0;
        recv_hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Check result beats first, then predict for the reading taken at this edge.
  always @(posedge clk) begin
    verdict_t         seen, want;
    reading_t         rd;
    rgbv_pkg::class_t cls;
    int               hits;
    if (!rst_n) begin
      in_beat_taken = 1'b0;
      out_beat_taken = 1'b0;
    end else begin
      out_beat_taken = out_ch.valid && out_ch.ready;
      if (out_beat_taken) begin
        seen.cls = out_ch.color_class;
        seen.confirmed = out_ch.confirmed;
        if (awaited_verdicts.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing awaited: expected none, %s %0d %0b",
                   $time, "actual class/confirmed", seen.cls, seen.confirmed);
        end else begin
          want = awaited_verdicts.pop_front();
          if (seen.cls !== want.cls) begin
            mismatches++;
            $display("%0t: color_class expected %0d actual %0d", $time, want.cls, seen.cls);
          end
          if (seen.confirmed !== want.confirmed) begin
            mismatches++;
            $display("%0t: confirmed expected %0b actual %0b", $time, want.confirmed,
                     seen.confirmed);
          end
        end
      end
      in_beat_taken = in_ch.valid && in_ch.ready;
      if (in_beat_taken) begin
        rd.red = in_ch.red_level;
        rd.green = in_ch.green_level;
        rd.blue = in_ch.blue_level;
        rd.vld = in_ch.reading_valid;
        rd.target = in_ch.target_class;
        cls = classify_reading(rd, thr);
        class_log[log_slot] = cls;
        log_slot = (log_slot + 1) % DEPTH;
        hits = 0;
        foreach (class_log[i])
          if (class_log[i] == rd.target) hits++;
        want.cls = cls;
        want.confirmed = (hits >= DEPTH - 1);
        awaited_verdicts.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rgbv_pkg::thresh_t defaults, t;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.red_level = '0;
    in_ch.green_level = '0;
    in_ch.blue_level = '0;
    in_ch.reading_valid = 1'b0;
    in_ch.target_class = rgbv_pkg::CLS_NONE;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    defaults = '{8'd130, 8'd120, 8'd100, 8'd80, 8'd30, 8'd65, 8'd20, 8'd60};
    thr = defaults;
    foreach (class_log[i]) class_log[i] = rgbv_pkg::CLS_NONE;
    log_slot = 0;
    mismatches = 0;
    cycles = 0;
    send_hold = 0;
    recv_hold = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Directed readings at the reset thresholds.
    add_reading(0, 0, 0, 1'b0, rgbv_pkg::CLS_NONE);   // ring still all none: vote passes at once
    add_reading(255, 255, 255, 1'b1, rgbv_pkg::CLS_WHITE);
    add_reading(130, 130, 130, 1'b1, rgbv_pkg::CLS_WHITE); // white needs strictly above
    add_reading(131, 131, 131, 1'b1, rgbv_pkg::CLS_WHITE);
    add_reading(200, 200, 99, 1'b1, rgbv_pkg::CLS_YELLOW);
    add_reading(200, 200, 100, 1'b1, rgbv_pkg::CLS_YELLOW);
    add_reading(255, 0, 0, 1'b1, rgbv_pkg::CLS_RED);
    add_reading(110, 80, 80, 1'b1, rgbv_pkg::CLS_RED);     // margin not exceeded
    add_reading(111, 80, 80, 1'b1, rgbv_pkg::CLS_RED);
    add_reading(0, 255, 0, 1'b1, rgbv_pkg::CLS_GREEN);
    add_reading(45, 66, 45, 1'b1, rgbv_pkg::CLS_GREEN);
    add_reading(0, 0, 255, 1'b1, rgbv_pkg::CLS_BLUE);
    add_reading(45, 45, 65, 1'b1, rgbv_pkg::CLS_BLUE);
    add_reading(59, 59, 59, 1'b1, rgbv_pkg::CLS_BLACK);
    add_reading(60, 0, 0, 1'b1, rgbv_pkg::CLS_BLACK);
    add_reading(255, 255, 255, 1'b0, rgbv_pkg::CLS_WHITE); // invalid reading still fills a slot
    add_reading(0, 255, 0, 1'b1, rgbv_pkg::class_t'(7));   // target code with no class
    for (int i = 0; i < 5; i++)
      add_reading(255, 0, 0, 1'b1, rgbv_pkg::CLS_RED);
    add_reading(255, 255, 0, 1'b1, rgbv_pkg::class_t'(7));
    add_reading(0, 0, 0, 1'b1, rgbv_pkg::CLS_NONE);
    queue_runs(RUN_READINGS);

    drain();
    load_thresholds('0);
    queue_runs(RUN_READINGS);

    drain();
    load_thresholds('1);
    queue_runs(RUN_READINGS);

    for (int p = 0; p < 2; p++) begin
      drain();
      t = rgbv_pkg::thresh_t'({$urandom, $urandom});
      t.red_margin = rgbv_pkg::level_t'($urandom_range(0, 60));
      t.green_blue_margin = rgbv_pkg::level_t'($urandom_range(0, 60));
      load_thresholds(t);
      queue_runs(RUN_READINGS);
    end

    drain();
    load_thresholds(defaults);
    queue_runs(RUN_READINGS);

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && awaited_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
design/rgbv_pkg.sv
design/rgbv_if.sv
design/rgbv_classify.sv
design/rgbv_cell.sv
design/rgb_color_class_vote.sv
test/tb.sv
